[rtl/bmrd_pkg.sv]
// Shared types, constants and helpers of the banked memory with RAM-disk mapper.
package bmrd_pkg;

   localparam int DISK_COUNT  = 8;
   localparam int DISK_IW     = 3;
   localparam int PAGE_BYTES  = 65536;
   localparam int ROM_BYTES   = 32768;
   localparam int STORE_BYTES = PAGE_BYTES * (1 + 4 * 8);
   localparam int STORE_AW    = 22;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [STORE_AW-1:0] STORE_LAST = STORE_AW'(STORE_BYTES - 1);
   localparam logic [STORE_AW-1:0] ROM_LIMIT  = STORE_AW'(ROM_BYTES);

   // The boot image carried by this build is blank.
   localparam logic [7:0] BOOT_FILL = 8'h00;

   localparam logic [7:0] MODE_BITS = 8'hF0;

   localparam logic [15:0] WIN_8000 = 16'h8000;
   localparam logic [15:0] WIN_A000 = 16'hA000;
   localparam logic [15:0] WIN_C000 = 16'hC000;
   localparam logic [15:0] WIN_E000 = 16'hE000;

   localparam logic [2:0] OP_READ   = 3'd0;
   localparam logic [2:0] OP_WRITE  = 3'd1;
   localparam logic [2:0] OP_MAP    = 3'd2;
   localparam logic [2:0] OP_ROM    = 3'd3;
   localparam logic [2:0] OP_SCREEN = 3'd4;
   localparam logic [2:0] OP_QUERY  = 3'd5;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] address;
      logic        stack_access;
      logic [7:0]  write_data;
      logic [2:0]  disk_index;
      logic [7:0]  mapping_byte;
      logic        rom_select;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [31:0] screen_word;
      logic        exception;
   } rsp_type;

   typedef enum logic [2:0] {
      KIND_PLAIN  = 3'd0,
      KIND_ROM    = 3'd1,
      KIND_READ   = 3'd2,
      KIND_WRITE  = 3'd3,
      KIND_SCREEN = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [STORE_AW-1:0]   addr;
      logic [7:0]            wdata;
      logic                  exc;
   } entry_type;

   function automatic logic [STORE_AW-1:0] plane_offset(input logic [1:0] plane);
      logic [15:0] base;
      case (plane)
         2'd0:    base = WIN_8000;
         2'd1:    base = WIN_A000;
         2'd2:    base = WIN_C000;
         default: base = WIN_E000;
      endcase
      return {{(STORE_AW-16){1'b0}}, base};
   endfunction

endpackage

[rtl/bmrd_front.sv]
// Front end: accepts requests, keeps the disk mapping state and resolves store addresses.
module bmrd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bmrd_pkg::req_type   req,
   input  logic                store_ready,
   input  logic                q_full,
   output logic                q_push,
   output bmrd_pkg::entry_type q_entry
);

   logic [7:0] dm_ff [bmrd_pkg::DISK_COUNT];
   logic [7:0] dm_in [bmrd_pkg::DISK_COUNT];
   logic [7:0] am_ff, am_in;
   logic [2:0] ad_ff, ad_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       ovl_ff, ovl_in;

   logic                          accept;
   logic                          in_window;
   logic [5:0]                    disk_base;
   logic [bmrd_pkg::STORE_AW-1:0] mapped;

   assign req_ready = store_ready && !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;

   assign disk_base = {1'b0, ad_ff, 2'b00} + 6'd1;

   assign in_window = (am_ff[5] && req.address >= bmrd_pkg::WIN_A000
                                && req.address < bmrd_pkg::WIN_E000)
                   || (am_ff[7] && req.address >= bmrd_pkg::WIN_8000
                                && req.address < bmrd_pkg::WIN_A000)
                   || (am_ff[6] && req.address >= bmrd_pkg::WIN_E000);

   always_comb begin
      if (am_ff[4] && req.stack_access) begin
         mapped = {disk_base + {4'd0, am_ff[3:2]}, req.address};
      end else if (in_window) begin
         mapped = {disk_base + {4'd0, am_ff[1:0]}, req.address};
      end else begin
         mapped = {6'd0, req.address};
      end
   end

   always_comb begin
      q_entry       = '0;
      q_entry.kind  = bmrd_pkg::KIND_PLAIN;
      q_entry.addr  = mapped;
      q_entry.wdata = req.write_data;
      case (req.operation)
         bmrd_pkg::OP_READ: begin
            q_entry.kind = (ovl_ff && mapped < bmrd_pkg::ROM_LIMIT) ?
                           bmrd_pkg::KIND_ROM : bmrd_pkg::KIND_READ;
         end
         bmrd_pkg::OP_WRITE: begin
            q_entry.kind = bmrd_pkg::KIND_WRITE;
         end
         bmrd_pkg::OP_SCREEN: begin
            q_entry.kind = bmrd_pkg::KIND_SCREEN;
            q_entry.addr = {6'd0, req.address};
         end
         bmrd_pkg::OP_QUERY: begin
            q_entry.exc = (cnt_ff == 2'd2);
         end
         default: begin
            q_entry.kind = bmrd_pkg::KIND_PLAIN;
         end
      endcase
   end

   always_comb begin
      dm_in  = dm_ff;
      am_in  = am_ff;
      ad_in  = ad_ff;
      cnt_in = cnt_ff;
      ovl_in = ovl_ff;
      if (accept) begin
         case (req.operation)
            bmrd_pkg::OP_MAP: begin
               if (int'(req.disk_index) < bmrd_pkg::DISK_COUNT) begin
                  dm_in[req.disk_index[bmrd_pkg::DISK_IW-1:0]] = req.mapping_byte;
               end
               // First enabled disk wins; the count saturates at two.
               am_in  = '0;
               cnt_in = '0;
               for (int i = 0; i < bmrd_pkg::DISK_COUNT; i++) begin
                  if ((dm_in[i] & bmrd_pkg::MODE_BITS) != 8'd0) begin
                     if (cnt_in == 2'd0) begin
                        am_in  = dm_in[i];
                        ad_in  = 3'(i);
                        cnt_in = 2'd1;
                     end else begin
                        cnt_in = 2'd2;
                     end
                  end
               end
            end
            bmrd_pkg::OP_ROM: begin
               ovl_in = req.rom_select;
            end
            bmrd_pkg::OP_QUERY: begin
               cnt_in = 2'd0;
            end
            default: begin
               cnt_in = cnt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bmrd_pkg::DISK_COUNT; i++) begin
            dm_ff[i] <= '0;
         end
         am_ff  <= '0;
         ad_ff  <= '0;
         cnt_ff <= '0;
         ovl_ff <= 1'b1;
      end else begin
         dm_ff  <= dm_in;
         am_ff  <= am_in;
         ad_ff  <= ad_in;
         cnt_ff <= cnt_in;
         ovl_ff <= ovl_in;
      end
   end

endmodule

[rtl/bmrd_queue.sv]
// Short queue that carries resolved requests from the front end to the store engine.
module bmrd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bmrd_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output bmrd_pkg::entry_type head
);

   bmrd_pkg::entry_type slot_ff [bmrd_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full      = (cnt_ff == 2'(bmrd_pkg::QUEUE_DEPTH));
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

[rtl/bmrd_back.sv]
// Store engine: owns the main store, clears it after reset and produces responses.
module bmrd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  bmrd_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                store_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bmrd_pkg::rsp_type   rsp
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [7:0] store [bmrd_pkg::STORE_BYTES];
   logic [7:0] mem_rd_ff;
   logic                          mem_we, mem_re;
   logic [bmrd_pkg::STORE_AW-1:0] mem_addr;
   logic [7:0]                    mem_wd;

   logic [bmrd_pkg::STORE_AW-1:0] clr_ff, clr_in;
   bmrd_pkg::entry_type           cur_ff, cur_in;
   logic [1:0]                    plane_ff, plane_in;
   logic [1:0]                    plane_nx;
   bmrd_pkg::rsp_type             res_ff, res_in;
   bmrd_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   assign store_ready = (state_ff != ST_CLEAR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp         = rsp_ff;
   assign plane_nx    = plane_ff + 2'd1;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      plane_in     = plane_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = '0;
      mem_wd       = '0;
      q_pop        = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            if (clr_ff == bmrd_pkg::STORE_LAST) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + {{(bmrd_pkg::STORE_AW-1){1'b0}}, 1'b1};
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop            = 1'b1;
               cur_in           = q_entry;
               plane_in         = 2'd0;
               res_in           = '0;
               res_in.exception = q_entry.exc;
               state_in         = ST_EMIT;
               case (q_entry.kind)
                  bmrd_pkg::KIND_READ: begin
                     mem_re   = 1'b1;
                     mem_addr = q_entry.addr;
                     state_in = ST_FETCH;
                  end
                  bmrd_pkg::KIND_SCREEN: begin
                     mem_re   = 1'b1;
                     mem_addr = q_entry.addr + bmrd_pkg::plane_offset(2'd0);
                     state_in = ST_FETCH;
                  end
                  bmrd_pkg::KIND_WRITE: begin
                     mem_we   = 1'b1;
                     mem_addr = q_entry.addr;
                     mem_wd   = q_entry.wdata;
                  end
                  bmrd_pkg::KIND_ROM: begin
                     res_in.read_data = bmrd_pkg::BOOT_FILL;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            // Takes the byte read last cycle; a screen read issues any next plane read.
            if (cur_ff.kind == bmrd_pkg::KIND_READ) begin
               res_in.read_data = mem_rd_ff;
               state_in         = ST_EMIT;
            end else begin
               res_in.screen_word = {res_ff.screen_word[23:0], mem_rd_ff};
               if (plane_ff == 2'd3) begin
                  state_in = ST_EMIT;
               end else begin
                  plane_in = plane_nx;
                  mem_re   = 1'b1;
                  mem_addr = cur_ff.addr + bmrd_pkg::plane_offset(plane_nx);
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_addr] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= store[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      plane_ff <= plane_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/banked_memory_with_ramdisk_mapper.sv]
// Top level of the banked memory with RAM-disk mapper.
// A CPU-side request channel (req_valid/req_ready/req) carries reads, writes, disk
// mapping writes, ROM overlay control, four-plane screen reads and exception
// queries. Every request yields exactly one response on rsp_valid/rsp_ready/rsp,
// in request order. The front end resolves the mapped store address and updates
// the mapping state in the accept cycle; a two-entry queue feeds the store engine,
// which owns a single-port main store of 2162688 bytes.
// A write, ROM read or control request passes the engine through its idle and emit
// states; a store read also passes the fetch state, and a screen read stays in the
// fetch state until its four plane reads through the one store port are done.
// After reset the engine zeroes all 2162688 bytes of the main store one byte per
// cycle, with req_ready held low. The mapping state resets to no disk active and
// the ROM overlay on.
// If the receiver stalls, the finished response is held in the output register,
// the engine holds one more finished result, and the queue and front end keep
// taking requests until the queue is full.
module banked_memory_with_ramdisk_mapper (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bmrd_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bmrd_pkg::rsp_type rsp
);

   logic                store_ready;
   logic                q_full, q_push, q_pop, q_not_empty;
   bmrd_pkg::entry_type push_entry, head;

   bmrd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .store_ready (store_ready),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (push_entry)
   );

   bmrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (head)
   );

   bmrd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_not_empty),
      .q_entry     (head),
      .q_pop       (q_pop),
      .store_ready (store_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp)
   );

endmodule
